// File: rtl/core/tsib_pkg.sv
// Shared types, codes and helper functions for the timestamped sample interval buffer.
// No dependencies; imported by tsib_ram users and the top level.
`default_nettype none

package tsib_pkg;

    localparam int TIME_W = 48;
    localparam int VAL_W  = 32;
    localparam int AXES   = 6;

    // Six Q16.16 channels: rate x,y,z then force x,y,z, element 0 in the low bits
    typedef logic [AXES-1:0][VAL_W-1:0] vec6_t;

    typedef logic [3:0] status_t;
    localparam status_t ST_INSERTED  = 4'd0;
    localparam status_t ST_INVALID   = 4'd1;
    localparam status_t ST_DUPLICATE = 4'd2;
    localparam status_t ST_ORDER     = 4'd3;
    localparam status_t ST_SEGMENT   = 4'd4;
    localparam status_t ST_BAD_RANGE = 4'd5;
    localparam status_t ST_EMPTY     = 4'd6;
    localparam status_t ST_START_OUT = 4'd7;
    localparam status_t ST_STOP_OUT  = 4'd8;
    localparam status_t ST_GAP       = 4'd9;

    // Configuration register indexes
    localparam logic CFG_BUF_CAPACITY = 1'b0;
    localparam logic CFG_MAX_GAP      = 1'b1;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef enum logic [4:0] {
        SQ_IDLE,
        SQ_INS_CHK,
        SQ_INS_WR,
        SQ_SCAN,
        SQ_CHK,
        SQ_GAP0,
        SQ_GAP,
        SQ_LDL,
        SQ_LDR,
        SQ_INTERP,
        SQ_DIV,
        SQ_MUL,
        SQ_ADD,
        SQ_IDONE,
        SQ_WALK,
        SQ_ENT,
        SQ_EMIT
    } seq_state_t;

    // One staged result
    typedef struct packed {
        logic              last;
        logic [5:0]        src;
        vec6_t             mean;
        logic [TIME_W-1:0] t1;
        logic [TIME_W-1:0] t0;
        logic [5:0]        ev;
        status_t           status;
    } result_t;

    function automatic result_t status_only(input status_t code);
        result_t r;
        r        = '0;
        r.status = code;
        r.last   = 1'b1;
        return r;
    endfunction

    // (a + b) / 2 truncated toward zero
    function automatic logic [VAL_W-1:0] mean2(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
        logic signed [VAL_W:0] s;
        s = $signed({a[VAL_W-1], a}) + $signed({b[VAL_W-1], b});
        s = s + $signed({{VAL_W{1'b0}}, s[VAL_W]});
        return s[VAL_W:1];
    endfunction

    function automatic vec6_t mean6(input vec6_t a, input vec6_t b);
        vec6_t r;
        for (int i = 0; i < AXES; i++) begin
            r[i] = mean2(a[i], b[i]);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/timestamped_sample_interval_buffer.sv
// Timestamped sample interval buffer: ring store of IMU samples with interval queries.
// Depends on tsib_pkg and tsib_ram.
//
// Requests arrive one at a time and are handled by a sequencer around two memories with
// registered read data (timestamps, and the six Q16.16 channels). An insert reads the
// newest time unless the store is empty, then writes. A query scans the stored samples
// to locate the start and stop knots, checks each source gap, runs two interpolations
// (two knot reads, a 16-step radix-2 fraction divider, then six multiply and add passes
// on a shared 17x33 multiplier), and walks the inner samples. Each result waits in an
// output register so the next request is taken while the last result is still pending.
// No clearing pass after reset: only entries that hold samples are ever read.
`default_nettype none

module timestamped_sample_interval_buffer #(
    parameter int CAPACITY = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // request: [47:0] time_ns, [95:48] end_time_ns, [127:96] rate_x, [159:128] rate_y,
    // [191:160] rate_z, [223:192] force_x, [255:224] force_y, [287:256] force_z
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [287:0] s_tdata,
    // [0] opcode, [1] sample_invalid
    input  wire logic [1:0]   s_tuser,
    // result: [3:0] status, [9:4] evicted_count, [57:10] span_start_ns,
    // [105:58] span_stop_ns, [137:106] mean_rate_x, [169:138] mean_rate_y,
    // [201:170] mean_rate_z, [233:202] mean_force_x, [265:234] mean_force_y,
    // [297:266] mean_force_z, [303:298] source_count
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [303:0]      m_tdata,
    output logic              m_tlast,          // last_result
    input  wire logic         cfg_we,
    input  wire logic         cfg_addr,
    input  wire logic [31:0]  cfg_wdata
);

    import tsib_pkg::*;

    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW:0] CAP_W = (CW + 1)'(CAPACITY);

    // ring slot of (base + k) with base < CAPACITY and k <= CAPACITY
    function automatic logic [SW-1:0] wrap_slot(input logic [CW:0] s);
        logic [CW:0] r;
        r = (s >= CAP_W) ? s - CAP_W : s;
        return r[SW-1:0];
    endfunction

    // ---------------- registers ----------------
    seq_state_t        state_reg, state_next;
    logic [SW-1:0]     oldest_reg, oldest_next;
    logic [CW-1:0]     fill_reg, fill_next;
    logic [5:0]        cap_reg;
    logic [31:0]       gap_reg;

    logic              op_reg, op_next;
    logic [47:0]       t0_reg, t0_next, t1_reg, t1_next;
    vec6_t             iv_reg, iv_next;                 // values of a pending insert

    logic [CW-1:0]     k_reg, k_next;
    logic [CW-1:0]     br_reg, br_next, er_reg, er_next;
    logic [CW-1:0]     bl_reg, bl_next, el_reg, el_next, ri_reg, ri_next;
    logic              brf_reg, brf_next, erf_reg, erf_next;
    logic              bre_reg, bre_next, ere_reg, ere_next;
    logic [47:0]       ta_reg, ta_next;

    logic [47:0]       lt_reg, lt_next, rt_reg, rt_next;
    vec6_t             lv_reg, lv_next, rv_reg, rv_next;
    logic [47:0]       ct_reg, ct_next, pt_reg, pt_next;
    vec6_t             cv_reg, cv_next, pv_reg, pv_next;
    logic [47:0]       tgt_reg, tgt_next;
    logic              fin_reg, fin_next;

    logic [47:0]       rem_reg, rem_next, den_reg, den_next;
    logic [15:0]       quo_reg, quo_next;
    logic [3:0]        step_reg, step_next;
    logic [2:0]        axis_reg, axis_next;
    logic signed [49:0] prod_reg, prod_next;

    result_t           st_reg, st_next;
    logic              mval_reg, mval_next;
    result_t           mres_reg, mres_next;

    // ---------------- memories ----------------
    logic              ram_we;
    logic [SW-1:0]     ram_waddr, ram_raddr;
    logic [47:0]       rtime;
    vec6_t             rvals;
    logic [CW-1:0]     rd_k;

    tsib_ram #(.WIDTH(TIME_W), .DEPTH(CAPACITY)) u_time_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (t0_reg),
        .raddr (ram_raddr),
        .rdata (rtime)
    );

    tsib_ram #(.WIDTH(AXES * VAL_W), .DEPTH(CAPACITY)) u_val_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (iv_reg),
        .raddr (ram_raddr),
        .rdata (rvals)
    );

    // ---------------- shared conditions ----------------
    logic          s_acc, in_op, in_inv, out_free;
    logic [47:0]   in_t0, in_t1;
    logic [CW-1:0] cap_eff, ev_w, one_k;
    logic [CW:0]   fill_p1;
    logic [SW-1:0] new_oldest;
    logic          hit_b, hit_e, scan_end, start_bad, stop_bad, gap_big, in_span;
    logic [CW-1:0] bl_c, el_c;
    logic [47:0]   rem2_sub;
    logic [48:0]   rem2;
    logic          div_ge;
    logic [32:0]   diff_a;
    logic signed [49:0] prod_adj;
    logic [33:0]   q_a, sum_a;
    logic [6:0]    cap7;

    assign one_k    = CW'(1);
    assign s_acc    = s_tvalid & s_tready;
    assign in_op    = s_tuser[0];
    assign in_inv   = s_tuser[1];
    assign in_t0    = s_tdata[47:0];
    assign in_t1    = s_tdata[95:48];
    assign out_free = !mval_reg || m_tready;

    // register value 0 acts as 1, anything above the store depth as the depth
    assign cap7    = {1'b0, cap_reg};
    assign cap_eff = (cap7 == 7'd0) ? one_k :
                     (cap7 > 7'(CAPACITY)) ? CW'(CAPACITY) : CW'(cap7);
    assign fill_p1 = {1'b0, fill_reg} + (CW + 1)'(1);
    assign ev_w    = (fill_p1 > {1'b0, cap_eff}) ? CW'(fill_p1 - {1'b0, cap_eff}) : '0;
    assign new_oldest = wrap_slot({{(CW + 1 - SW){1'b0}}, oldest_reg} + {1'b0, ev_w});

    assign hit_b     = rtime >= t0_reg;
    assign hit_e     = rtime >= t1_reg;
    assign scan_end  = (k_reg + one_k == fill_reg) || (hit_e && !erf_reg);
    assign start_bad = !brf_reg || (br_reg == '0 && !bre_reg);
    assign stop_bad  = !erf_reg;
    assign bl_c      = bre_reg ? br_reg : br_reg - one_k;
    assign el_c      = ere_reg ? er_reg : er_reg - one_k;
    assign gap_big   = (rtime - ta_reg) > {16'd0, gap_reg};
    assign in_span   = (rtime > t0_reg) && (rtime < t1_reg);

    // one radix-2 step of the fraction divider
    assign rem2     = {rem_reg, 1'b0};
    assign div_ge   = rem2 >= {1'b0, den_reg};
    assign rem2_sub = 48'(rem2 - {1'b0, den_reg});

    // interpolation: frac * (right - left), then truncate toward zero by 2^16
    assign diff_a   = {rv_reg[axis_reg][31], rv_reg[axis_reg]}
                    - {lv_reg[axis_reg][31], lv_reg[axis_reg]};
    assign prod_adj = prod_reg + (prod_reg[49] ? 50'sd65535 : 50'sd0);
    assign q_a      = 34'(prod_adj >>> 16);
    assign sum_a    = {{2{lv_reg[axis_reg][31]}}, lv_reg[axis_reg]} + q_a;

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            SQ_IDLE: begin
                if (s_acc) begin
                    if (in_op == OP_INSERT) begin
                        if (in_inv) state_next = SQ_EMIT;
                        else if (fill_reg == '0) state_next = SQ_INS_WR;
                        else state_next = SQ_INS_CHK;
                    end else begin
                        if (in_t1 <= in_t0 || fill_reg == '0) state_next = SQ_EMIT;
                        else state_next = SQ_SCAN;
                    end
                end
            end
            SQ_INS_CHK: state_next = (rtime >= t0_reg) ? SQ_EMIT : SQ_INS_WR;
            SQ_INS_WR:  state_next = SQ_EMIT;
            SQ_SCAN:    state_next = scan_end ? SQ_CHK : SQ_SCAN;
            SQ_CHK:     state_next = (start_bad || stop_bad) ? SQ_EMIT : SQ_GAP0;
            SQ_GAP0:    state_next = SQ_GAP;
            SQ_GAP: begin
                if (gap_big) state_next = SQ_EMIT;
                else if (k_reg == er_reg) state_next = SQ_LDL;
            end
            SQ_LDL:     state_next = SQ_LDR;
            SQ_LDR:     state_next = SQ_INTERP;
            SQ_INTERP: begin
                if (tgt_reg == lt_reg || tgt_reg == rt_reg) state_next = SQ_IDONE;
                else state_next = SQ_DIV;
            end
            SQ_DIV:     state_next = (step_reg == 4'd15) ? SQ_MUL : SQ_DIV;
            SQ_MUL:     state_next = SQ_ADD;
            SQ_ADD:     state_next = (axis_reg == 3'(AXES - 1)) ? SQ_IDONE : SQ_MUL;
            SQ_IDONE:   state_next = fin_reg ? SQ_EMIT : SQ_WALK;
            SQ_WALK:    state_next = (k_reg == er_reg) ? SQ_LDL : SQ_ENT;
            SQ_ENT:     state_next = in_span ? SQ_EMIT : SQ_WALK;
            SQ_EMIT: begin
                if (out_free) state_next = st_reg.last ? SQ_IDLE : SQ_WALK;
            end
            default:    state_next = SQ_IDLE;
        endcase
    end

    // ---------------- datapath and memory control ----------------
    always_comb begin
        oldest_next = oldest_reg;
        fill_next   = fill_reg;
        op_next     = op_reg;
        t0_next     = t0_reg;
        t1_next     = t1_reg;
        iv_next     = iv_reg;
        k_next      = k_reg;
        br_next     = br_reg;
        er_next     = er_reg;
        bl_next     = bl_reg;
        el_next     = el_reg;
        ri_next     = ri_reg;
        brf_next    = brf_reg;
        erf_next    = erf_reg;
        bre_next    = bre_reg;
        ere_next    = ere_reg;
        ta_next     = ta_reg;
        lt_next     = lt_reg;
        rt_next     = rt_reg;
        lv_next     = lv_reg;
        rv_next     = rv_reg;
        ct_next     = ct_reg;
        cv_next     = cv_reg;
        pt_next     = pt_reg;
        pv_next     = pv_reg;
        tgt_next    = tgt_reg;
        fin_next    = fin_reg;
        rem_next    = rem_reg;
        den_next    = den_reg;
        quo_next    = quo_reg;
        step_next   = step_reg;
        axis_next   = axis_reg;
        prod_next   = prod_reg;
        st_next     = st_reg;
        mval_next   = mval_reg && !m_tready;
        mres_next   = mres_reg;
        ram_we      = 1'b0;
        ram_waddr   = wrap_slot({{(CW + 1 - SW){1'b0}}, new_oldest}
                                + {1'b0, fill_reg - ev_w});
        rd_k        = k_reg;

        case (state_reg)
            SQ_IDLE: begin
                rd_k = (in_op == OP_QUERY) ? '0 : fill_reg - one_k;
                if (s_acc) begin
                    op_next  = in_op;
                    t0_next  = in_t0;
                    t1_next  = in_t1;
                    iv_next  = s_tdata[287:96];
                    k_next   = '0;
                    brf_next = 1'b0;
                    erf_next = 1'b0;
                    if (in_op == OP_INSERT) begin
                        if (in_inv) st_next = status_only(ST_INVALID);
                    end else if (in_t1 <= in_t0) begin
                        st_next = status_only(ST_BAD_RANGE);
                    end else if (fill_reg == '0) begin
                        st_next = status_only(ST_EMPTY);
                    end
                end
            end
            SQ_INS_CHK: begin
                if (rtime == t0_reg) st_next = status_only(ST_DUPLICATE);
                else if (rtime > t0_reg) st_next = status_only(ST_ORDER);
            end
            SQ_INS_WR: begin
                ram_we      = 1'b1;
                oldest_next = new_oldest;
                fill_next   = fill_reg - ev_w + one_k;
                st_next     = status_only(ST_INSERTED);
                st_next.ev  = 6'(ev_w);
            end
            SQ_SCAN: begin
                rd_k = k_reg + one_k;
                if (!brf_reg && hit_b) begin
                    brf_next = 1'b1;
                    br_next  = k_reg;
                    bre_next = rtime == t0_reg;
                end
                if (!erf_reg && hit_e) begin
                    erf_next = 1'b1;
                    er_next  = k_reg;
                    ere_next = rtime == t1_reg;
                end
                k_next = k_reg + one_k;
            end
            SQ_CHK: begin
                rd_k    = bl_c;
                bl_next = bl_c;
                el_next = el_c;
                k_next  = bl_c;
                if (start_bad) st_next = status_only(ST_START_OUT);
                else if (stop_bad) st_next = status_only(ST_STOP_OUT);
            end
            SQ_GAP0: begin
                rd_k    = k_reg + one_k;
                ta_next = rtime;
                k_next  = k_reg + one_k;
            end
            SQ_GAP: begin
                if (gap_big) begin
                    st_next    = status_only(ST_GAP);
                    st_next.t0 = ta_reg;
                    st_next.t1 = rtime;
                end else if (k_reg == er_reg) begin
                    // start knot: left bl, right br, target start time
                    rd_k     = bl_reg;
                    ri_next  = br_reg;
                    tgt_next = t0_reg;
                    fin_next = 1'b0;
                end else begin
                    rd_k    = k_reg + one_k;
                    ta_next = rtime;
                    k_next  = k_reg + one_k;
                end
            end
            SQ_LDL: begin
                rd_k    = ri_reg;
                lt_next = rtime;
                lv_next = rvals;
            end
            SQ_LDR: begin
                rt_next = rtime;
                rv_next = rvals;
            end
            SQ_INTERP: begin
                if (tgt_reg == lt_reg) begin
                    ct_next = lt_reg;
                    cv_next = lv_reg;
                end else if (tgt_reg == rt_reg) begin
                    ct_next = rt_reg;
                    cv_next = rv_reg;
                end else begin
                    ct_next   = tgt_reg;
                    rem_next  = tgt_reg - lt_reg;
                    den_next  = rt_reg - lt_reg;
                    quo_next  = '0;
                    step_next = '0;
                end
            end
            SQ_DIV: begin
                rem_next  = div_ge ? rem2_sub : rem2[47:0];
                quo_next  = {quo_reg[14:0], div_ge};
                step_next = step_reg + 4'd1;
                axis_next = '0;
            end
            SQ_MUL: begin
                prod_next = $signed({1'b0, quo_reg}) * $signed(diff_a);
            end
            SQ_ADD: begin
                cv_next[axis_reg] = sum_a[31:0];
                axis_next         = axis_reg + 3'd1;
            end
            SQ_IDONE: begin
                if (fin_reg) begin
                    st_next        = status_only(ST_SEGMENT);
                    st_next.t0     = pt_reg;
                    st_next.t1     = ct_reg;
                    st_next.mean   = mean6(pv_reg, cv_reg);
                    st_next.src    = 6'(er_reg - bl_reg + one_k);
                end else begin
                    pt_next = ct_reg;
                    pv_next = cv_reg;
                    k_next  = bl_reg + one_k;
                end
            end
            SQ_WALK: begin
                if (k_reg == er_reg) begin
                    // stop knot: left el, right er, target stop time
                    rd_k     = el_reg;
                    ri_next  = er_reg;
                    tgt_next = t1_reg;
                    fin_next = 1'b1;
                end
            end
            SQ_ENT: begin
                ct_next = rtime;
                cv_next = rvals;
                if (in_span) begin
                    st_next      = status_only(ST_SEGMENT);
                    st_next.last = 1'b0;
                    st_next.t0   = pt_reg;
                    st_next.t1   = rtime;
                    st_next.mean = mean6(pv_reg, rvals);
                    st_next.src  = 6'(er_reg - bl_reg + one_k);
                end else begin
                    k_next = k_reg + one_k;
                end
            end
            SQ_EMIT: begin
                if (out_free) begin
                    mval_next = 1'b1;
                    mres_next = st_reg;
                    if (!st_reg.last) begin
                        pt_next = ct_reg;
                        pv_next = cv_reg;
                        k_next  = k_reg + one_k;
                    end
                end
            end
            default: begin
            end
        endcase

        ram_raddr = wrap_slot({{(CW + 1 - SW){1'b0}}, oldest_reg} + {1'b0, rd_k});
    end

    // ---------------- control registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= SQ_IDLE;
            mval_reg   <= 1'b0;
            oldest_reg <= '0;
            fill_reg   <= '0;
            cap_reg    <= 6'd32;
            gap_reg    <= 32'd10000000;
        end else begin
            state_reg  <= state_next;
            mval_reg   <= mval_next;
            oldest_reg <= oldest_next;
            fill_reg   <= fill_next;
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_BUF_CAPACITY: cap_reg <= cfg_wdata[5:0];
                    CFG_MAX_GAP:      gap_reg <= cfg_wdata;
                    default:          cap_reg <= cap_reg;
                endcase
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        t0_reg   <= t0_next;
        t1_reg   <= t1_next;
        iv_reg   <= iv_next;
        k_reg    <= k_next;
        br_reg   <= br_next;
        er_reg   <= er_next;
        bl_reg   <= bl_next;
        el_reg   <= el_next;
        ri_reg   <= ri_next;
        brf_reg  <= brf_next;
        erf_reg  <= erf_next;
        bre_reg  <= bre_next;
        ere_reg  <= ere_next;
        ta_reg   <= ta_next;
        lt_reg   <= lt_next;
        rt_reg   <= rt_next;
        lv_reg   <= lv_next;
        rv_reg   <= rv_next;
        ct_reg   <= ct_next;
        cv_reg   <= cv_next;
        pt_reg   <= pt_next;
        pv_reg   <= pv_next;
        tgt_reg  <= tgt_next;
        fin_reg  <= fin_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
        axis_reg <= axis_next;
        prod_reg <= prod_next;
        st_reg   <= st_next;
        mres_reg <= mres_next;
    end

    // ---------------- ports ----------------
    assign s_tready = (state_reg == SQ_IDLE);
    assign m_tvalid = mval_reg;
    assign m_tlast  = mres_reg.last;
    assign m_tdata  = {mres_reg.src, mres_reg.mean, mres_reg.t1, mres_reg.t0,
                       mres_reg.ev, mres_reg.status};

    // ---------------- assertions ----------------
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CW'(CAPACITY))
        else $error("fill count beyond store depth");

    a_oldest_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, oldest_reg} < CAP_W)
        else $error("oldest slot outside the ring");

    a_insert_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == SQ_INS_WR |=> fill_reg != '0)
        else $error("store empty after a write");

    a_last_idles: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SQ_EMIT && out_free && st_reg.last) |=> state_reg == SQ_IDLE)
        else $error("sequencer busy after final result");

    a_seg_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (mval_reg && mres_reg.status == ST_SEGMENT) |-> mres_reg.t1 > mres_reg.t0)
        else $error("segment stop not after start");

endmodule

`default_nettype wire

// File: rtl/core/tsib_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module tsib_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: tb/timestamped_sample_interval_buffer_test.sv
// Self-checking bench for the timestamped sample interval buffer.
// Needs tsib_pkg and the block; an internal predictor works out every result.
`default_nettype none

module timestamped_sample_interval_buffer_test;
    import tsib_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH     = 32;
    localparam int LIMIT     = 900000;   // cycles before the run is declared hung
    localparam int TAIL_WAIT = 250;      // extra wait after the last expected result arrives

    // one request as the bench builds it
    typedef struct {
        logic              op;
        logic [TIME_W-1:0] t0;
        logic [TIME_W-1:0] t1;
        logic              bad;
        logic [31:0]       v[6];
    } request_t;

    // one result, field by field
    typedef struct {
        status_t           status;
        logic [5:0]        ev;
        logic [TIME_W-1:0] t0;
        logic [TIME_W-1:0] t1;
        logic [31:0]       mean[6];
        logic [5:0]        src;
        logic              last;
    } outcome_t;

    typedef struct {
        logic [TIME_W-1:0] t;
        longint            v[6];
    } knot_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    wire  logic   s_tready;
    logic [287:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    wire  logic   m_tvalid;
    logic         m_tready = 1'b0;
    wire  logic [303:0] m_tdata;
    wire  logic   m_tlast;
    logic         cfg_we = 1'b0;
    logic         cfg_addr = CFG_BUF_CAPACITY;
    logic [31:0]  cfg_wdata = '0;

    timestamped_sample_interval_buffer #(.CAPACITY(DEPTH)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shadow of the block's store and registers
    logic [TIME_W-1:0] sh_time[DEPTH];
    longint            sh_val[DEPTH][6];
    int unsigned       sh_oldest, sh_fill;
    logic [5:0]        sh_capacity;
    logic [31:0]       sh_max_gap;

    outcome_t pending_results[$];

    int idle_pct, stall_pct, hold_cycles;
    int mismatches, results_seen, requests_sent, segments_seen, gap_errors;
    int cycles;

    // ---------------------------------------------------------------- predictor
    function automatic logic [TIME_W-1:0] stored_time(int unsigned k);
        return sh_time[(sh_oldest + k) % DEPTH];
    endfunction

    function automatic knot_t stored_knot(int unsigned k);
        knot_t r;
        int unsigned s;
        s = (sh_oldest + k) % DEPTH;
        r.t = sh_time[s];
        for (int a = 0; a < 6; a++) r.v[a] = sh_val[s][a];
        return r;
    endfunction

    function automatic knot_t knot_between(int unsigned li, int unsigned ri,
                                           logic [TIME_W-1:0] t);
        knot_t l, r, o;
        logic [TIME_W-1:0] d, w;
        logic [63:0] frac;
        l = stored_knot(li);
        r = stored_knot(ri);
        if (t == l.t) return l;
        if (t == r.t) return r;
        d = t - l.t;
        w = r.t - l.t;
        frac = ({16'd0, d} << 16) / {16'd0, w};
        o.t = t;
        for (int a = 0; a < 6; a++)
            o.v[a] = l.v[a] + (longint'(frac) * (r.v[a] - l.v[a])) / 64'sd65536;
        return o;
    endfunction

    function automatic outcome_t status_result(status_t code);
        outcome_t r;
        r.status = code;
        r.ev = '0;
        r.t0 = '0;
        r.t1 = '0;
        foreach (r.mean[a]) r.mean[a] = '0;
        r.src = '0;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic int unsigned first_not_before(logic [TIME_W-1:0] t);
        int unsigned k;
        k = 0;
        while (k < sh_fill && stored_time(k) < t) k++;
        return k;
    endfunction

    // works out every result of one accepted request and advances the shadow state
    function automatic void predict_request(request_t rq);
        outcome_t r;
        int unsigned cap, ev, s, br, er, bl, el;
        logic [TIME_W-1:0] ta, tb;
        knot_t prev, cur;
        if (rq.op == OP_INSERT) begin
            cap = (sh_capacity == 0) ? 1 : (sh_capacity > DEPTH) ? DEPTH : sh_capacity;
            if (rq.bad) begin
                pending_results.push_back(status_result(ST_INVALID));
                return;
            end
            if (sh_fill > 0) begin
                if (rq.t0 == stored_time(sh_fill - 1)) begin
                    pending_results.push_back(status_result(ST_DUPLICATE));
                    return;
                end
                if (rq.t0 < stored_time(sh_fill - 1)) begin
                    pending_results.push_back(status_result(ST_ORDER));
                    return;
                end
            end
            ev = (sh_fill + 1 > cap) ? sh_fill + 1 - cap : 0;
            sh_oldest = (sh_oldest + ev) % DEPTH;
            sh_fill -= ev;
            s = (sh_oldest + sh_fill) % DEPTH;
            sh_time[s] = rq.t0;
            for (int a = 0; a < 6; a++) sh_val[s][a] = longint'($signed(rq.v[a]));
            sh_fill++;
            r = status_result(ST_INSERTED);
            r.ev = ev[5:0];
            pending_results.push_back(r);
            return;
        end
        // query: checks in fixed order
        if (rq.t1 <= rq.t0) begin
            pending_results.push_back(status_result(ST_BAD_RANGE));
            return;
        end
        if (sh_fill == 0) begin
            pending_results.push_back(status_result(ST_EMPTY));
            return;
        end
        br = first_not_before(rq.t0);
        if (br == sh_fill || (br == 0 && stored_time(0) != rq.t0)) begin
            pending_results.push_back(status_result(ST_START_OUT));
            return;
        end
        er = first_not_before(rq.t1);
        if (er == sh_fill) begin
            pending_results.push_back(status_result(ST_STOP_OUT));
            return;
        end
        bl = (stored_time(br) == rq.t0) ? br : br - 1;
        el = (stored_time(er) == rq.t1) ? er : er - 1;
        for (int unsigned k = bl; k < er; k++) begin
            ta = stored_time(k);
            tb = stored_time(k + 1);
            if (tb - ta > {16'd0, sh_max_gap}) begin
                r = status_result(ST_GAP);
                r.t0 = ta;
                r.t1 = tb;
                pending_results.push_back(r);
                return;
            end
        end
        prev = knot_between(bl, br, rq.t0);
        for (int unsigned k = bl + 1; k <= er; k++) begin
            if (k == er) begin
                cur = knot_between(el, er, rq.t1);
            end else begin
                cur = stored_knot(k);
                if (!(cur.t > rq.t0 && cur.t < rq.t1)) continue;
            end
            r = status_result(ST_SEGMENT);
            r.t0 = prev.t;
            r.t1 = cur.t;
            for (int a = 0; a < 6; a++) r.mean[a] = 32'((prev.v[a] + cur.v[a]) / 2);
            r.src = 6'(er - bl + 1);
            r.last = (k == er);
            pending_results.push_back(r);
            prev = cur;
        end
    endfunction

    // ---------------------------------------------------------------- result side
    // receiver: random stalls, or a counted hold-off when hold_cycles is set
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready = 1'b0;
            hold_cycles = hold_cycles - 1;
        end else begin
            m_tready = ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        outcome_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tdata[3:0];
            got.ev     = m_tdata[9:4];
            got.t0     = m_tdata[57:10];
            got.t1     = m_tdata[105:58];
            for (int a = 0; a < 6; a++) got.mean[a] = m_tdata[106 + 32*a +: 32];
            got.src    = m_tdata[303:298];
            got.last   = m_tlast;
            results_seen++;
            if (got.status == ST_SEGMENT) segments_seen++;
            if (got.status == ST_GAP) gap_errors++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result, status %0d", $realtime, got.status);
            end else begin
                want = pending_results.pop_front();
                if (want.status !== got.status || want.ev !== got.ev ||
                    want.t0 !== got.t0 || want.t1 !== got.t1 || want.src !== got.src ||
                    want.last !== got.last || want.mean != got.mean) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("[%0t] result mismatch", $realtime);
                        $display("  expected st=%0d ev=%0d t=%0h..%0h src=%0d last=%0b",
                                 want.status, want.ev, want.t0, want.t1, want.src, want.last);
                        $display("  actual   st=%0d ev=%0d t=%0h..%0h src=%0d last=%0b",
                                 got.status, got.ev, got.t0, got.t1, got.src, got.last);
                        for (int a = 0; a < 6; a++)
                            if (want.mean[a] !== got.mean[a])
                                $display("  mean[%0d] expected %0h actual %0h",
                                         a, want.mean[a], got.mean[a]);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- request side
    task automatic send_request(request_t rq);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {rq.v[5], rq.v[4], rq.v[3], rq.v[2], rq.v[1], rq.v[0], rq.t1, rq.t0};
        s_tuser  = {rq.bad, rq.op};
        do @(posedge aclk); while (!s_tready);
        predict_request(rq);
        requests_sent++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (TAIL_WAIT) @(posedge aclk);
    endtask

    // register write once the block has gone quiet
    task automatic write_reg(logic idx, logic [31:0] value);
        drain();
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_addr = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we = 1'b0;
        if (idx == CFG_BUF_CAPACITY) sh_capacity = value[5:0];
        else sh_max_gap = value;
    endtask

    function automatic logic [TIME_W-1:0] rand_time();
        return {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF;
    endfunction

    function automatic request_t make_insert(logic [TIME_W-1:0] t, logic bad = 1'b0);
        request_t rq;
        rq.op = OP_INSERT;
        rq.t0 = t;
        rq.t1 = rand_time();
        rq.bad = bad;
        foreach (rq.v[a]) rq.v[a] = $urandom;
        return rq;
    endfunction

    function automatic request_t make_query(logic [TIME_W-1:0] t0, logic [TIME_W-1:0] t1);
        request_t rq;
        rq = make_insert(t0, $urandom_range(1));
        rq.op = OP_QUERY;
        rq.t1 = t1;
        return rq;
    endfunction

    // ---------------------------------------------------------------- tests
    task automatic test_insert_outcomes();
        request_t rq;
        send_request(make_query(48'd0, 48'd1));          // empty store
        send_request(make_query(48'd50, 48'd50));        // stop equal to start
        send_request(make_insert(48'd100, 1'b1));        // invalid sample
        rq = make_insert(48'd1000);
        foreach (rq.v[a]) rq.v[a] = 32'h8000_0000;
        send_request(rq);
        send_request(make_insert(48'd1000));             // duplicate
        send_request(make_insert(48'd500));              // older
        rq = make_insert(48'd3000);
        foreach (rq.v[a]) rq.v[a] = 32'h7FFF_FFFF;
        send_request(rq);
        send_request(make_insert(48'd6000));
    endtask

    task automatic test_query_outcomes();
        send_request(make_query(48'd1000, 48'd6000));    // knots on stored times
        send_request(make_query(48'd1500, 48'd4000));    // interpolated ends
        send_request(make_query(48'd2999, 48'd3001));    // one stored sample inside
        send_request(make_query(48'd999, 48'd2000));     // start before oldest
        send_request(make_query(48'd1000, 48'd7000));    // stop past newest
        send_request(make_query(48'd7000, 48'd8000));    // start past newest
        send_request(make_query(48'd2000, 48'd1000));    // reversed span
    endtask

    task automatic test_gap_limits();
        write_reg(CFG_MAX_GAP, 32'd2000);
        send_request(make_query(48'd1000, 48'd6000));    // 3000..6000 too wide
        write_reg(CFG_MAX_GAP, 32'd0);
        send_request(make_query(48'd1000, 48'd3000));    // every gap too wide
        write_reg(CFG_MAX_GAP, 32'hFFFF_FFFF);
        send_request(make_insert(48'hFFFF_FFFF_FFFE));
        send_request(make_insert(48'hFFFF_FFFF_FFFF));
        send_request(make_query(48'hFFFF_FFFF_FFFE, 48'hFFFF_FFFF_FFFF));
        send_request(make_query(48'd6000, 48'hFFFF_FFFF_FFFF)); // gap over 32 bits
    endtask

    task automatic test_capacity_limits();
        write_reg(CFG_BUF_CAPACITY, 32'd0);              // acts as one
        send_request(make_insert(48'd0));                // older than newest
        write_reg(CFG_BUF_CAPACITY, 32'd63);             // acts as the full depth
        write_reg(CFG_BUF_CAPACITY, 32'd1);
        send_request(make_query(48'hFFFF_FFFF_FFFE, 48'hFFFF_FFFF_FFFF));
    endtask

    // mostly well-formed traffic around the stored span, some broken requests
    task automatic random_request();
        request_t rq;
        logic [TIME_W-1:0] lo, hi, t0, t1, newest;
        int pick;
        pick = $urandom_range(99);
        newest = (sh_fill == 0) ? 48'd0 : stored_time(sh_fill - 1);
        if (pick < 52) begin
            send_request(make_insert(newest + $urandom_range(1500, 1)));
        end else if (pick < 60) begin
            case ($urandom_range(3))
                0: rq = make_insert(newest + $urandom_range(1500, 1), 1'b1);
                1: rq = make_insert(newest);
                2: rq = make_insert(newest - $urandom_range(3000, 1));
                default: rq = make_insert(rand_time());
            endcase
            send_request(rq);
        end else if (pick < 93 && sh_fill > 0) begin
            lo = stored_time(0);
            hi = newest;
            t0 = lo + (({$urandom, $urandom}) % ({16'd0, hi - lo} + 64'd1));
            if ($urandom_range(7) == 0) t0 = stored_time($urandom_range(sh_fill - 1));
            if ($urandom_range(15) == 0 && lo != 0) t0 = lo - 1;
            t1 = t0 + 1 + (({$urandom, $urandom}) % ({16'd0, hi - t0} + 64'd200));
            if ($urandom_range(7) == 0) t1 = stored_time($urandom_range(sh_fill - 1));
            send_request(make_query(t0, t1));
        end else begin
            send_request(make_query(rand_time(), rand_time()));
        end
    endtask

    task automatic test_random_phase(int sender_idle, int receiver_stall, int count);
        logic [5:0] caps[7] = '{6'd1, 6'd2, 6'd4, 6'd8, 6'd32, 6'd0, 6'd63};
        logic [31:0] gaps[4] = '{32'd60, 32'd2000, 32'd10000000, 32'hFFFF_FFFF};
        write_reg(CFG_BUF_CAPACITY,
                  ($urandom_range(3) == 0) ? $urandom_range(63) : caps[$urandom_range(6)]);
        write_reg(CFG_MAX_GAP, gaps[$urandom_range(3)]);
        idle_pct = sender_idle;
        stall_pct = receiver_stall;
        repeat (count) random_request();
        idle_pct = 0;
        stall_pct = 0;
    endtask

    // receiver holds off while requests keep coming, then the sender waits for all
    task automatic test_backpressure();
        write_reg(CFG_BUF_CAPACITY, 32'd32);
        write_reg(CFG_MAX_GAP, 32'd10000000);
        @(negedge aclk);
        hold_cycles = 400;
        repeat (20) random_request();
        drain();
        repeat (10) random_request();
    endtask

    initial begin
        idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 0;
        mismatches = 0;
        results_seen = 0;
        requests_sent = 0;
        segments_seen = 0;
        gap_errors = 0;
        cycles = 0;
        sh_oldest = 0;
        sh_fill = 0;
        sh_capacity = 6'd32;
        sh_max_gap = 32'd10000000;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        test_insert_outcomes();
        test_query_outcomes();
        test_gap_limits();
        test_capacity_limits();
        test_random_phase(0, 0, 55);
        test_random_phase(76, 0, 55);
        test_random_phase(0, 76, 55);
        test_random_phase(19, 19, 55);
        test_backpressure();
        drain();

        $display("%0d requests, %0d results (%0d segments, %0d gap errors), %0d cycles",
                 requests_sent, results_seen, segments_seen, gap_errors, cycles);
        $display("covered capacity and gap extremes, idle/stall phases and a long hold-off");
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
rtl/core/tsib_pkg.sv
rtl/core/tsib_ram.sv
rtl/core/timestamped_sample_interval_buffer.sv
tb/timestamped_sample_interval_buffer_test.sv
